### rtl/lmse_pkg.sv
// shared types and constants for the lsb marker search extractor
`default_nettype none

package lmse_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int LEN_W       = 4;
  localparam int CHAR_W      = 8;
  localparam int SHIFT_W     = 7;
  localparam int COUNT_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_LENGTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MARKER_PATTERN = 1'b1;

  localparam logic [COUNT_W-1:0] LAST_BIT = 3'd7;
  localparam logic [CHAR_W-1:0]  NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [CHAR_W-1:0] channel_sample;
    logic              image_start;
    logic              image_end;
  } sample_t;

  typedef struct packed {
    logic [CHAR_W-1:0] message_byte;
    logic              byte_valid;
    logic              message_done;
    logic              marker_found;
  } result_t;

endpackage

`default_nettype wire

### rtl/lmse_stream_if.sv
// valid/ready channel interfaces for samples and results
`default_nettype none

interface lmse_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_sample;
  logic       image_start;
  logic       image_end;

  modport source (output valid, output channel_sample, output image_start,
                  output image_end, input ready);
  modport sink (input valid, input channel_sample, input image_start,
                input image_end, output ready);
endinterface

interface lmse_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_valid;
  logic       message_done;
  logic       marker_found;

  modport source (output valid, output message_byte, output byte_valid,
                  output message_done, output marker_found, input ready);
  modport sink (input valid, input message_byte, input byte_valid,
                input message_done, input marker_found, output ready);
endinterface

`default_nettype wire

### rtl/lmse_decoder.sv
// decoding state and per-sample bit assembly, marker compare and result build
`default_nettype none

module lmse_decoder #(
  parameter int MAX_MARKER = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire lmse_pkg::sample_t                   item,
  input  wire logic [lmse_pkg::LEN_W-1:0]          marker_length,
  input  wire logic [8*MAX_MARKER-1:0]             marker_pattern,
  output lmse_pkg::result_t                        res,
  output logic                                     has_result
);

  localparam int WIN_W  = 8 * MAX_MARKER;
  localparam int FILL_W = $clog2(MAX_MARKER + 1);

  logic [lmse_pkg::SHIFT_W-1:0] bit_shift, bit_shift_next;
  logic [lmse_pkg::COUNT_W-1:0] bit_count, bit_count_next;
  logic [WIN_W-1:0]             char_window, char_window_next;
  logic [FILL_W-1:0]            window_fill, window_fill_next;
  logic                         found_flag, found_flag_next;
  logic                         stopped_flag, stopped_flag_next;

  logic [lmse_pkg::LEN_W-1:0]   eff_len;
  logic [lmse_pkg::CHAR_W-1:0]  ch;
  logic                         have_char;
  logic                         emit;
  logic                         done;
  logic [MAX_MARKER-1:0]        byte_ok;
  logic                         match;

  // clamp the configured length into 1..MAX_MARKER
  always_comb begin
    if (marker_length == '0) begin
      eff_len = lmse_pkg::LEN_W'(1);
    end else if (marker_length > lmse_pkg::LEN_W'(MAX_MARKER)) begin
      eff_len = lmse_pkg::LEN_W'(MAX_MARKER);
    end else begin
      eff_len = marker_length;
    end
  end

  always_comb begin
    bit_shift_next    = bit_shift;
    bit_count_next    = bit_count;
    char_window_next  = char_window;
    window_fill_next  = window_fill;
    found_flag_next   = found_flag;
    stopped_flag_next = stopped_flag;
    ch                = lmse_pkg::NUL_CHAR;
    have_char         = 1'b0;
    emit              = 1'b0;
    done              = 1'b0;
    byte_ok           = '0;
    match             = 1'b0;

    if (item.image_start) begin
      bit_shift_next    = '0;
      bit_count_next    = '0;
      char_window_next  = '0;
      window_fill_next  = '0;
      found_flag_next   = 1'b0;
      stopped_flag_next = 1'b0;
    end

    if (!stopped_flag_next) begin
      if (bit_count_next == lmse_pkg::LAST_BIT) begin
        ch             = {bit_shift_next, item.channel_sample[0]};
        have_char      = 1'b1;
        bit_shift_next = '0;
        bit_count_next = '0;
      end else begin
        bit_shift_next = {bit_shift_next[lmse_pkg::SHIFT_W-2:0], item.channel_sample[0]};
        bit_count_next = bit_count_next + lmse_pkg::COUNT_W'(1);
      end
    end

    if (have_char) begin
      if (!found_flag_next) begin
        char_window_next = (char_window_next << 8) | WIN_W'(ch);
        if (window_fill_next < FILL_W'(MAX_MARKER)) begin
          window_fill_next = window_fill_next + FILL_W'(1);
        end
        // bytes above the marker length always compare equal
        for (int i = 0; i < MAX_MARKER; i++) begin
          byte_ok[i] = (lmse_pkg::LEN_W'(i) >= eff_len) ||
                       (char_window_next[8*i +: 8] == marker_pattern[8*i +: 8]);
        end
        match = (&byte_ok) && (lmse_pkg::LEN_W'(window_fill_next) >= eff_len);
        if (match) begin
          found_flag_next = 1'b1;
        end
      end else begin
        emit = 1'b1;
        if (ch == lmse_pkg::NUL_CHAR) begin
          done              = 1'b1;
          stopped_flag_next = 1'b1;
        end
      end
    end

    if (item.image_end) begin
      done              = 1'b1;
      stopped_flag_next = 1'b1;
    end
  end

  always_comb begin
    has_result       = emit || done;
    res.message_byte = emit ? ch : lmse_pkg::NUL_CHAR;
    res.byte_valid   = emit;
    res.message_done = done;
    res.marker_found = found_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift    <= '0;
      bit_count    <= '0;
      char_window  <= '0;
      window_fill  <= '0;
      found_flag   <= 1'b0;
      stopped_flag <= 1'b0;
    end else if (advance) begin
      bit_shift    <= bit_shift_next;
      bit_count    <= bit_count_next;
      char_window  <= char_window_next;
      window_fill  <= window_fill_next;
      found_flag   <= found_flag_next;
      stopped_flag <= stopped_flag_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lsb_marker_search_extractor.sv
// LSB marker search extractor: one colour sample enters per cycle and its least
// significant bit is shifted into a character, eight bits most significant first.
// Until the configured marker (marker_length characters of marker_pattern, the
// newest character in byte 0) is seen in the sliding window, characters are only
// compared; after it, each character is returned as a message byte, a zero
// character ends the message and the image's last sample always returns a status
// result. The block takes one sample per clock cycle unless the output stalls; a
// sample is held in the input register and its result is captured in the output
// register, the two register stages. The user must write the registers only while
// no sample is in flight; the block itself does not enforce this.
`default_nettype none

module lsb_marker_search_extractor #(
  parameter int MAX_MARKER = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [lmse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lmse_pkg::CFG_DATA_W-1:0]     cfg_data,
  lmse_sample_if.sink                              sample,
  lmse_result_if.source                            result
);

  localparam int WIN_W = 8 * MAX_MARKER;

  logic [lmse_pkg::LEN_W-1:0] marker_length;
  logic [WIN_W-1:0]           marker_pattern;

  logic               s1_valid;
  lmse_pkg::sample_t  s1_item;
  logic               s1_take;

  logic               out_valid;
  lmse_pkg::result_t  out_item;

  lmse_pkg::result_t  dec_res;
  logic               dec_has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_length  <= lmse_pkg::LEN_W'(1);
      marker_pattern <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lmse_pkg::CFG_MARKER_LENGTH: begin
          marker_length <= cfg_data[lmse_pkg::LEN_W-1:0];
        end
        lmse_pkg::CFG_MARKER_PATTERN: begin
          marker_pattern <= cfg_data[WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // the input stage drains whenever the output register is free or being read
  assign s1_take      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_item.channel_sample <= sample.channel_sample;
      s1_item.image_start    <= sample.image_start;
      s1_item.image_end      <= sample.image_end;
    end
  end

  lmse_decoder #(
    .MAX_MARKER (MAX_MARKER)
  ) u_decoder (
    .clk            (clk),
    .rst            (rst),
    .advance        (s1_take),
    .item           (s1_item),
    .marker_length  (marker_length),
    .marker_pattern (marker_pattern),
    .res            (dec_res),
    .has_result     (dec_has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= dec_has_result;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_item <= dec_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.message_byte = out_item.message_byte;
  assign result.byte_valid   = out_item.byte_valid;
  assign result.message_done = out_item.message_done;
  assign result.marker_found = out_item.marker_found;

endmodule

`default_nettype wire

### rtl/lmse_checker.sv
// port-level checks for the lsb marker search extractor and their binding
`default_nettype none

module lmse_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] message_byte,
  input wire logic       byte_valid,
  input wire logic       message_done,
  input wire logic       marker_found
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(message_byte) &&
      $stable(byte_valid) && $stable(message_done) && $stable(marker_found))
    else $error("result changed while stalled");

  // message bytes only follow a matched marker
  a_byte_after_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> marker_found)
    else $error("message byte without marker");

  // a zero character ends the message
  a_nul_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid && (message_byte == 8'h00) |-> message_done)
    else $error("zero character without done");

  // a status-only result carries done and a zero byte
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> message_done && (message_byte == 8'h00))
    else $error("empty result without done");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind lsb_marker_search_extractor lmse_checker u_lmse_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .message_byte (result.message_byte),
  .byte_valid   (result.byte_valid),
  .message_done (result.message_done),
  .marker_found (result.marker_found)
);

`default_nettype wire
